>>> rtl/gred_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gred_pkg
// Shared types and constants of the 5x5 binomial pyramid reduce block.
// ============================================================================
package gred_pkg;

    // Fixed field and datapath widths.
    localparam int SRC_WIDTH_W  = 12;
    localparam int SRC_HEIGHT_W = 16;
    localparam int PIXEL_W      = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int HSUM_W       = 12;   // one horizontal 1-4-6-4-1 sum, at most 4080
    localparam int STORE_W      = 16;   // one column-sum line store entry
    localparam int ACC_W        = 20;   // vertical sum before scaling
    localparam int SCALE_SHIFT  = 8;    // the kernel weights add up to 256

    // Kernel weights and the sums that border replication folds together.
    localparam int KERNEL_NEAR   = 4;
    localparam int KERNEL_CENTRE = 6;
    localparam int KERNEL_TOP    = 5;   // outer plus near weight at the top border
    localparam int KERNEL_EDGE   = 11;  // outer, near and centre weight at a border
    localparam int ROUND_BIAS    = 128;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_ENABLE = 2'd2;

    // Input item operations.
    localparam logic OPERATION_PIXEL = 1'b0;
    localparam logic OPERATION_DRAIN = 1'b1;

    // Kinds of column operation handed to the vertical stage.
    localparam logic [2:0] KIND_ROW0        = 3'd0;
    localparam logic [2:0] KIND_ODD         = 3'd1;
    localparam logic [2:0] KIND_EVEN        = 3'd2;
    localparam logic [2:0] KIND_DRAIN_ODD   = 3'd3;
    localparam logic [2:0] KIND_DRAIN_EVEN  = 3'd4;

    typedef struct packed {
        logic               operation;
        logic [PIXEL_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               row_end;
        logic               image_end;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [HSUM_W-1:0] hsum;
        logic              row_end;
        logic              image_end;
        logic              last;
    } col_op_t;

endpackage

>>> rtl/gaussian_reduce_5x5_gray_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// gaussian_reduce_5x5_gray_unit
// Halves an 8-bit gray image in both directions with a 5x5 binomial filter.
// ============================================================================
// Source pixels enter in raster order on the s_ channel (operation pixel) and
// reduced pixels leave on the m_ channel, each with row_end, image_end and a
// last flag that marks the final result of the item that caused it. Once the
// image has ended, one drain item per output pixel flushes the final output row.
// Configuration (width, height, rounding) is written through cfg_we; the user
// must do so only while the block is idle, which the block does not enforce.
// A result passes through the column operation register and then the result
// register before it is presented on m_valid. Throughput is one item per
// cycle while the receiver keeps up; the last pixel of a row at an even column
// past the first yields two column operations and holds s_ready low while the
// second one waits. The rate is set by the single read and write port of each
// line store. Reset clears the position counters, the row registers and both
// pipeline stages; the line stores are not cleared, every entry is written
// before it is read. When the receiver stalls, one column operation waits
// behind the result register and then s_ready falls until the result is taken.
// ============================================================================
module gaussian_reduce_5x5_gray_unit #(
    parameter int MAX_SRC_WIDTH = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [gred_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gred_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  gred_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output gred_pkg::out_item_t                 m_data
);

    localparam int AW = $clog2((MAX_SRC_WIDTH + 1) / 2 + 1);

    // Configuration registers, reset to a 640 by 480 image with rounding.
    logic [gred_pkg::SRC_WIDTH_W-1:0]  src_width_reg, src_width_next;
    logic [gred_pkg::SRC_HEIGHT_W-1:0] src_height_reg, src_height_next;
    logic                              round_enable_reg, round_enable_next;

    // Column operations travel from the horizontal to the vertical stage.
    logic              op_valid;
    logic              op_ready;
    gred_pkg::col_op_t col_op;
    logic [AW-1:0]     op_addr;

    always_comb begin
        src_width_next    = src_width_reg;
        src_height_next   = src_height_reg;
        round_enable_next = round_enable_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                gred_pkg::CFG_SRC_WIDTH: begin
                    src_width_next = cfg_wdata[gred_pkg::SRC_WIDTH_W-1:0];
                end
                gred_pkg::CFG_SRC_HEIGHT: begin
                    src_height_next = cfg_wdata[gred_pkg::SRC_HEIGHT_W-1:0];
                end
                gred_pkg::CFG_ROUND_ENABLE: begin
                    round_enable_next = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg    <= gred_pkg::SRC_WIDTH_W'(640);
            src_height_reg   <= gred_pkg::SRC_HEIGHT_W'(480);
            round_enable_reg <= 1'b1;
        end else begin
            src_width_reg    <= src_width_next;
            src_height_reg   <= src_height_next;
            round_enable_reg <= round_enable_next;
        end
    end

    // Horizontal filtering and raster tracking; issues at most one column
    // operation per cycle and holds the second one of a row end.
    gred_hsum #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH)) u_hsum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .op_valid   (op_valid),
        .op_ready   (op_ready),
        .op         (col_op),
        .op_addr    (op_addr)
    );

    // Vertical filtering over the three column-sum line stores and the
    // result register.
    gred_vsum #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH)) u_vsum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op           (col_op),
        .op_addr      (op_addr),
        .round_enable (round_enable_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

>>> rtl/gred_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// gred_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
module gred_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1025
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/gred_hsum.sv
`timescale 1ns / 1ps
// ============================================================================
// gred_hsum
// Raster position counters, horizontal 1-4-6-4-1 sums and column op issue.
// ============================================================================
module gred_hsum #(
    parameter int MAX_SRC_WIDTH = 2048
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_valid,
    output logic                                         s_ready,
    input  gred_pkg::in_item_t                           s_data,
    input  logic [gred_pkg::SRC_WIDTH_W-1:0]             src_width,
    input  logic [gred_pkg::SRC_HEIGHT_W-1:0]            src_height,
    output logic                                         op_valid,
    input  logic                                         op_ready,
    output gred_pkg::col_op_t                            op,
    output logic [$clog2((MAX_SRC_WIDTH + 1) / 2 + 1)-1:0] op_addr
);

    localparam int CW   = $clog2(MAX_SRC_WIDTH);
    localparam int WW   = $clog2(MAX_SRC_WIDTH + 1);
    localparam int XW   = WW + 1;
    localparam int AW   = $clog2((MAX_SRC_WIDTH + 1) / 2 + 1);
    localparam int CMPW = (WW > gred_pkg::SRC_WIDTH_W) ? WW : gred_pkg::SRC_WIDTH_W;
    localparam int HW   = gred_pkg::HSUM_W;
    localparam int HTW  = gred_pkg::SRC_HEIGHT_W;
    localparam int PW   = gred_pkg::PIXEL_W;

    logic [CW-1:0]     col_cnt_reg, col_cnt_next;
    logic [HTW-1:0]    row_cnt_reg, row_cnt_next;
    logic [AW-1:0]     drain_cnt_reg, drain_cnt_next;
    logic [PW-1:0]     last_pix_reg, last_pix_next;
    logic [10:0]       partial_reg, partial_next;
    logic [9:0]        odd_reg, odd_next;
    logic              pend_valid_reg, pend_valid_next;
    gred_pkg::col_op_t pend_op_reg, pend_op_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;

    logic [CMPW-1:0]   sw_ext;
    logic [CMPW-1:0]   max_ext;
    logic [WW-1:0]     w_eff;
    logic [HTW-1:0]    h_eff;
    logic [AW-1:0]     dw;
    logic              accept;
    logic              is_drain;
    logic              img_active;
    logic              pix_go;
    logic              drain_go;
    logic [PW-1:0]     pixel;
    logic [XW-1:0]     x_next1;
    logic              x_last;
    logic              x_odd;
    logic              x_zero;
    logic [9:0]        quad_pix;
    logic [PW-1:0]     last_pix_eff;
    logic [9:0]        odd_eff;
    logic [10:0]       partial_new;
    logic [HW-1:0]     h_a;
    logic [HW-1:0]     h_b;
    logic              has_a;
    logic              has_b;
    logic [AW-1:0]     k_a;
    logic [AW-1:0]     k_b;
    logic [2:0]        row_kind;
    logic [AW:0]       drain_next1;
    logic              final_d;
    gred_pkg::col_op_t op_a;
    gred_pkg::col_op_t op_b;
    gred_pkg::col_op_t op_d;

    // Effective image size: zero acts as one, the width saturates at the maximum.
    assign sw_ext  = CMPW'(src_width);
    assign max_ext = CMPW'(MAX_SRC_WIDTH);
    assign w_eff   = (sw_ext == '0) ? WW'(1) :
                     ((sw_ext > max_ext) ? WW'(max_ext) : WW'(sw_ext));
    assign h_eff   = (src_height == '0) ? HTW'(1) : src_height;
    assign dw      = AW'((XW'(w_eff) + XW'(1)) >> 1);

    assign s_ready    = op_ready && !pend_valid_reg;
    assign accept     = s_valid && s_ready;
    assign is_drain   = (s_data.operation == gred_pkg::OPERATION_DRAIN);
    assign img_active = (row_cnt_reg < h_eff);
    assign pix_go     = accept && !is_drain && img_active;
    assign drain_go   = accept && is_drain && !img_active;
    assign pixel      = s_data.pixel_in;

    assign x_next1 = XW'(col_cnt_reg) + XW'(1);
    assign x_last  = (x_next1 >= XW'(w_eff));
    assign x_odd   = col_cnt_reg[0];
    assign x_zero  = (col_cnt_reg == '0);

    // Horizontal sums; the first pixel of a row is replicated to the left.
    assign quad_pix     = 10'(pixel) * 10'(gred_pkg::KERNEL_NEAR);
    assign last_pix_eff = x_zero ? pixel : last_pix_reg;
    assign odd_eff      = x_zero ? quad_pix : odd_reg;
    assign partial_new  = 11'(last_pix_eff) + 11'(odd_eff);
    assign h_a = HW'(partial_reg) + HW'(last_pix_reg) * HW'(gred_pkg::KERNEL_CENTRE)
               + HW'(x_odd ? quad_pix : odd_reg) + HW'(pixel);
    assign h_b = HW'(partial_new) + HW'(pixel) * HW'(gred_pkg::KERNEL_EDGE);

    assign has_a = x_odd ? x_last : !x_zero;
    assign has_b = !x_odd && x_last;
    assign k_a   = x_odd ? AW'(x_next1 >> 1) : AW'(col_cnt_reg >> 1);
    assign k_b   = AW'(col_cnt_reg >> 1) + AW'(1);

    always_comb begin
        if (row_cnt_reg == '0) begin
            row_kind = gred_pkg::KIND_ROW0;
        end else if (row_cnt_reg[0]) begin
            row_kind = gred_pkg::KIND_ODD;
        end else begin
            row_kind = gred_pkg::KIND_EVEN;
        end
    end

    assign drain_next1 = (AW + 1)'(drain_cnt_reg) + (AW + 1)'(1);
    assign final_d     = (drain_next1 >= (AW + 1)'(dw));

    always_comb begin
        op_a.kind      = row_kind;
        op_a.hsum      = h_a;
        op_a.row_end   = x_odd;
        op_a.image_end = 1'b0;
        op_a.last      = !has_b;

        op_b.kind      = row_kind;
        op_b.hsum      = h_b;
        op_b.row_end   = 1'b1;
        op_b.image_end = 1'b0;
        op_b.last      = 1'b1;

        op_d.kind      = row_cnt_reg[0] ? gred_pkg::KIND_DRAIN_ODD : gred_pkg::KIND_DRAIN_EVEN;
        op_d.hsum      = '0;
        op_d.row_end   = final_d;
        op_d.image_end = final_d;
        op_d.last      = 1'b1;
    end

    always_comb begin
        col_cnt_next    = col_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        drain_cnt_next  = drain_cnt_reg;
        last_pix_next   = last_pix_reg;
        partial_next    = partial_reg;
        odd_next        = odd_reg;
        pend_valid_next = pend_valid_reg && !op_ready;
        pend_op_next    = pend_op_reg;
        pend_addr_next  = pend_addr_reg;
        op_valid        = 1'b0;
        op              = pend_op_reg;
        op_addr         = pend_addr_reg;

        // A held second op goes first; no item is taken while it waits.
        if (pend_valid_reg) begin
            op_valid = 1'b1;
        end else if (drain_go) begin
            op_valid = 1'b1;
            op       = op_d;
            op_addr  = AW'(drain_next1);
        end else if (pix_go && has_a) begin
            op_valid = 1'b1;
            op       = op_a;
            op_addr  = k_a;
            if (has_b) begin
                pend_valid_next = 1'b1;
                pend_op_next    = op_b;
                pend_addr_next  = k_b;
            end
        end else if (pix_go && has_b) begin
            op_valid = 1'b1;
            op       = op_b;
            op_addr  = k_b;
        end

        if (pix_go) begin
            if (x_odd || x_zero) begin
                odd_next = quad_pix;
            end
            if (!x_odd) begin
                partial_next  = partial_new;
                last_pix_next = pixel;
            end
            if (x_last) begin
                col_cnt_next = '0;
                row_cnt_next = row_cnt_reg + HTW'(1);
            end else begin
                col_cnt_next = CW'(x_next1);
            end
        end

        if (drain_go) begin
            if (final_d) begin
                drain_cnt_next = '0;
                row_cnt_next   = '0;
                col_cnt_next   = '0;
            end else begin
                drain_cnt_next = AW'(drain_next1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            drain_cnt_reg  <= '0;
            last_pix_reg   <= '0;
            partial_reg    <= '0;
            odd_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            col_cnt_reg    <= col_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            drain_cnt_reg  <= drain_cnt_next;
            last_pix_reg   <= last_pix_next;
            partial_reg    <= partial_next;
            odd_reg        <= odd_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_op_reg   <= pend_op_next;
        pend_addr_reg <= pend_addr_next;
    end

    a_pend_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg && op_ready |=> !pend_valid_reg)
        else $error("held second column op was not released");

    a_drain_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_go && final_d |=>
            (row_cnt_reg == '0) && (col_cnt_reg == '0) && (drain_cnt_reg == '0))
        else $error("counters not cleared after the final drain item");

endmodule

>>> rtl/gred_vsum.sv
`timescale 1ns / 1ps
// ============================================================================
// gred_vsum
// Column-sum line stores, vertical 1-4-6-4-1 sums and the result register.
// ============================================================================
module gred_vsum #(
    parameter int MAX_SRC_WIDTH = 2048
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         op_valid,
    output logic                                         op_ready,
    input  gred_pkg::col_op_t                            op,
    input  logic [$clog2((MAX_SRC_WIDTH + 1) / 2 + 1)-1:0] op_addr,
    input  logic                                         round_enable,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output gred_pkg::out_item_t                          m_data
);

    localparam int DEPTH = (MAX_SRC_WIDTH + 1) / 2 + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = gred_pkg::STORE_W;
    localparam int ACW   = gred_pkg::ACC_W;

    logic                st1_valid_reg, st1_valid_next;
    gred_pkg::col_op_t   st1_op_reg, st1_op_next;
    logic [AW-1:0]       st1_addr_reg, st1_addr_next;
    logic [2:0]          byp_hit_reg, byp_hit_next;
    logic [SW-1:0]       byp_cur_reg, byp_cur_next;
    logic [SW-1:0]       byp_prv_reg, byp_prv_next;
    logic [SW-1:0]       byp_pnd_reg, byp_pnd_next;
    logic                m_valid_reg, m_valid_next;
    gred_pkg::out_item_t m_data_reg, m_data_next;

    logic          load;
    logic          produces;
    logic          out_free;
    logic          st1_fire;
    logic [SW-1:0] rd_cur, rd_prv, rd_pnd;
    logic [SW-1:0] cur_val, prv_val, pnd_val;
    logic          cur_we, prv_we, pnd_we;
    logic          cur_sel, prv_sel, pnd_sel;
    logic [SW-1:0] cur_wdata, prv_wdata, pnd_wdata;
    logic          prv_top;
    logic [ACW-1:0] c_term, pd_term, h_term, acc, scaled;

    // Read data is replaced by the value written at the edge of the read.
    assign cur_val = byp_hit_reg[0] ? byp_cur_reg : rd_cur;
    assign prv_val = byp_hit_reg[1] ? byp_prv_reg : rd_prv;
    assign pnd_val = byp_hit_reg[2] ? byp_pnd_reg : rd_pnd;

    always_comb begin
        produces = 1'b0;
        cur_sel  = 1'b0;
        prv_sel  = 1'b0;
        pnd_sel  = 1'b0;
        prv_top  = 1'b0;
        c_term   = '0;
        pd_term  = '0;
        h_term   = '0;
        unique case (st1_op_reg.kind)
            gred_pkg::KIND_ROW0: begin
                cur_sel = 1'b1;
                prv_sel = 1'b1;
                prv_top = 1'b1;
            end
            gred_pkg::KIND_ODD: begin
                pnd_sel = 1'b1;
            end
            gred_pkg::KIND_EVEN: begin
                cur_sel  = 1'b1;
                prv_sel  = 1'b1;
                produces = 1'b1;
                c_term   = ACW'(cur_val) * ACW'(gred_pkg::KERNEL_CENTRE);
                pd_term  = ACW'(pnd_val);
                h_term   = ACW'(st1_op_reg.hsum);
            end
            gred_pkg::KIND_DRAIN_ODD: begin
                produces = 1'b1;
                c_term   = ACW'(cur_val) * ACW'(gred_pkg::KERNEL_EDGE);
            end
            gred_pkg::KIND_DRAIN_EVEN: begin
                produces = 1'b1;
                c_term   = ACW'(cur_val) * ACW'(gred_pkg::KERNEL_CENTRE);
                pd_term  = ACW'(pnd_val) + ACW'(pnd_val >> 2);
            end
            default: begin
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;
    assign st1_fire = st1_valid_reg && (!produces || out_free);
    assign op_ready = !st1_valid_reg || st1_fire;
    assign load     = op_valid && op_ready;

    assign cur_we    = st1_fire && cur_sel;
    assign prv_we    = st1_fire && prv_sel;
    assign pnd_we    = st1_fire && pnd_sel;
    assign cur_wdata = SW'(st1_op_reg.hsum);
    assign prv_wdata = prv_top ?
                       SW'(ACW'(st1_op_reg.hsum) * ACW'(gred_pkg::KERNEL_TOP)) :
                       cur_val + pnd_val;
    assign pnd_wdata = SW'(ACW'(st1_op_reg.hsum) * ACW'(gred_pkg::KERNEL_NEAR));

    assign acc    = ACW'(prv_val) + c_term + pd_term + h_term;
    assign scaled = acc + (round_enable ? ACW'(gred_pkg::ROUND_BIAS) : ACW'(0));

    gred_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_cur_ram (
        .aclk  (aclk),
        .we    (cur_we),
        .waddr (st1_addr_reg),
        .wdata (cur_wdata),
        .re    (load),
        .raddr (op_addr),
        .rdata (rd_cur)
    );

    gred_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_prv_ram (
        .aclk  (aclk),
        .we    (prv_we),
        .waddr (st1_addr_reg),
        .wdata (prv_wdata),
        .re    (load),
        .raddr (op_addr),
        .rdata (rd_prv)
    );

    gred_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_pnd_ram (
        .aclk  (aclk),
        .we    (pnd_we),
        .waddr (st1_addr_reg),
        .wdata (pnd_wdata),
        .re    (load),
        .raddr (op_addr),
        .rdata (rd_pnd)
    );

    always_comb begin
        st1_valid_next = st1_valid_reg;
        st1_op_next    = st1_op_reg;
        st1_addr_next  = st1_addr_reg;
        byp_hit_next   = byp_hit_reg;
        byp_cur_next   = byp_cur_reg;
        byp_prv_next   = byp_prv_reg;
        byp_pnd_next   = byp_pnd_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (load) begin
            st1_valid_next  = 1'b1;
            st1_op_next     = op;
            st1_addr_next   = op_addr;
            byp_hit_next[0] = cur_we && (st1_addr_reg == op_addr);
            byp_hit_next[1] = prv_we && (st1_addr_reg == op_addr);
            byp_hit_next[2] = pnd_we && (st1_addr_reg == op_addr);
            byp_cur_next    = cur_wdata;
            byp_prv_next    = prv_wdata;
            byp_pnd_next    = pnd_wdata;
        end else if (st1_fire) begin
            st1_valid_next = 1'b0;
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (st1_fire && produces) begin
            m_valid_next          = 1'b1;
            m_data_next.pixel_out = scaled[gred_pkg::SCALE_SHIFT +: gred_pkg::PIXEL_W];
            m_data_next.row_end   = st1_op_reg.row_end;
            m_data_next.image_end = st1_op_reg.image_end;
            m_data_next.last      = st1_op_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            byp_hit_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            byp_hit_reg   <= byp_hit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        st1_op_reg   <= st1_op_next;
        st1_addr_reg <= st1_addr_next;
        byp_cur_reg  <= byp_cur_next;
        byp_prv_reg  <= byp_prv_next;
        byp_pnd_reg  <= byp_pnd_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && !op_ready |=>
            st1_valid_reg && $stable(st1_addr_reg) && $stable(st1_op_reg))
        else $error("stalled column op changed");

    a_write_sets: assert property (@(posedge aclk) disable iff (!aresetn)
        pnd_we |-> !cur_we && !prv_we)
        else $error("pending store written together with the other stores");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(st1_valid_reg))
        else $error("result appeared without a column op");

endmodule
